>>> sv/sdrq_pkg.sv
// ============================================================================
// sdrq_pkg
// Shared types and codes for the SSTF disk request queue: request and
// response words, command and status codes, cell strobes, control states.
// ============================================================================
`default_nettype none

package sdrq_pkg;

  // fixed widths of the word fields
  localparam int CYL_FIELD_W   = 13;
  localparam int COUNT_FIELD_W = 7;
  localparam int STATUS_W      = 3;
  localparam int COMMAND_W     = 2;

  // command codes; the high bit alone selects set head
  localparam logic [COMMAND_W-1:0] CMD_ADD   = 2'd0;
  localparam logic [COMMAND_W-1:0] CMD_SERVE = 2'd1;
  localparam int                   CMD_SET_BIT = 1;

  // status codes
  localparam logic [STATUS_W-1:0] STAT_ADDED  = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_SERVED = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL   = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_EMPTY  = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_HEAD   = 3'd4;

  typedef struct packed {
    logic [COMMAND_W-1:0]   command;
    logic [CYL_FIELD_W-1:0] cylinder;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic [CYL_FIELD_W-1:0]   served_cylinder;
    logic [CYL_FIELD_W-1:0]   seek_distance;
    logic [COUNT_FIELD_W-1:0] queue_count;
  } rsp_t;

  // strobes broadcast to every cell
  typedef struct packed {
    logic add;     // write the new request at the tail
    logic remove;  // close the gap at the chosen entry
    logic start;   // launch a search token into cell 0
  } cell_ctrl_t;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

endpackage

`default_nettype wire

>>> sv/sdrq_cell.sv
// ============================================================================
// sdrq_cell
// One queue slot. Holds a cylinder, computes its distance to the head and
// forwards the nearest-so-far search token to the next cell each cycle.
// ============================================================================
`default_nettype none

module sdrq_cell
  import sdrq_pkg::*;
#(
  parameter int CB    = 13,
  parameter int IW    = 6,
  parameter int CW    = 7,
  parameter int INDEX = 0
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire cell_ctrl_t    ctrl,
  input  wire logic [CB-1:0] add_cyl,
  input  wire logic [CW-1:0] count,
  input  wire logic [IW-1:0] rm_idx,
  input  wire logic [CB-1:0] head,
  input  wire logic [CB-1:0] next_val,
  output logic      [CB-1:0] val,
  input  wire logic          tin_v,
  input  wire logic          tin_has,
  input  wire logic [CB-1:0] tin_d,
  input  wire logic [IW-1:0] tin_idx,
  input  wire logic [CB-1:0] tin_cyl,
  output logic               tout_v,
  output logic               tout_has,
  output logic      [CB-1:0] tout_d,
  output logic      [IW-1:0] tout_idx,
  output logic      [CB-1:0] tout_cyl
);

  logic          occupied;
  logic [CB-1:0] slot_d;
  logic          take;

  // slot holds a pending request, and how far it is from the head
  assign occupied = CW'(INDEX) < count;
  assign slot_d   = (head >= val) ? (head - val) : (val - head);
  // strict compare keeps the older entry on a tie
  assign take     = occupied && (!tin_has || (slot_d < tin_d));

  // token valid travels one cell per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      tout_v <= 1'b0;
    end else begin
      tout_v <= tin_v;
    end
  end

  // token payload: pass it on or replace it with this slot
  always_ff @(posedge clk) begin
    if (tin_v) begin
      if (take) begin
        tout_has <= 1'b1;
        tout_d   <= slot_d;
        tout_idx <= IW'(INDEX);
        tout_cyl <= val;
      end else begin
        tout_has <= tin_has;
        tout_d   <= tin_d;
        tout_idx <= tin_idx;
        tout_cyl <= tin_cyl;
      end
    end
  end

  // storage: tail write on add, shift down from the neighbor on remove
  always_ff @(posedge clk) begin
    if (ctrl.add && (count == CW'(INDEX))) begin
      val <= add_cyl;
    end else if (ctrl.remove && (IW'(INDEX) >= rm_idx)) begin
      val <= next_val;
    end
  end

endmodule

`default_nettype wire

>>> sv/sdrq_chain.sv
// ============================================================================
// sdrq_chain
// Row of queue cells. Slot 0 is the oldest request. The search token enters
// at slot 0 and leaves the last slot with the nearest request found.
// ============================================================================
`default_nettype none

module sdrq_chain
  import sdrq_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int CB    = 13,
  parameter int IW    = 6,
  parameter int CW    = 7
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire cell_ctrl_t    ctrl,
  input  wire logic [CB-1:0] add_cyl,
  input  wire logic [CW-1:0] count,
  input  wire logic [IW-1:0] rm_idx,
  input  wire logic [CB-1:0] head,
  output logic               done,
  output logic               found,
  output logic      [CB-1:0] best_d,
  output logic      [IW-1:0] best_idx,
  output logic      [CB-1:0] best_cyl
);

  logic [CB-1:0] vals  [DEPTH];
  logic [CB-1:0] nexts [DEPTH];
  logic          tv    [DEPTH+1];
  logic          th    [DEPTH+1];
  logic [CB-1:0] td    [DEPTH+1];
  logic [IW-1:0] ti    [DEPTH+1];
  logic [CB-1:0] tc    [DEPTH+1];

  // token enters empty; cell 0 always takes it
  assign tv[0] = ctrl.start;
  assign th[0] = 1'b0;
  assign td[0] = '0;
  assign ti[0] = '0;
  assign tc[0] = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    // last slot refills from itself; its content is past the tail anyway
    if (i == DEPTH - 1) begin : g_last
      assign nexts[i] = vals[i];
    end else begin : g_mid
      assign nexts[i] = vals[i+1];
    end

    sdrq_cell #(
      .CB    (CB),
      .IW    (IW),
      .CW    (CW),
      .INDEX (i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .add_cyl  (add_cyl),
      .count    (count),
      .rm_idx   (rm_idx),
      .head     (head),
      .next_val (nexts[i]),
      .val      (vals[i]),
      .tin_v    (tv[i]),
      .tin_has  (th[i]),
      .tin_d    (td[i]),
      .tin_idx  (ti[i]),
      .tin_cyl  (tc[i]),
      .tout_v   (tv[i+1]),
      .tout_has (th[i+1]),
      .tout_d   (td[i+1]),
      .tout_idx (ti[i+1]),
      .tout_cyl (tc[i+1])
    );
  end

  assign done     = tv[DEPTH];
  assign found    = th[DEPTH];
  assign best_d   = td[DEPTH];
  assign best_idx = ti[DEPTH];
  assign best_cyl = tc[DEPTH];

endmodule

`default_nettype wire

>>> sv/sstf_disk_request_queue.sv
// ============================================================================
// sstf_disk_request_queue
// Shortest-seek-time-first disk request queue built as a row of cells.
// ============================================================================
//
//  channel | signals                      | word
//  --------+------------------------------+-----------------------------------
//  request | req_valid, req_stall, req    | command, cylinder
//  result  | rsp_valid, rsp_stall, rsp    | status, served/seek, queue_count
//
// Add, set head, full drop and empty serve: result formed at the accepting
// edge, moved to the output register once that register can take it. A serve
// of a non-empty queue: the token walks the row, one cell per cycle, then the
// gap closes and the result is formed, then the word moves out. Reset empties
// the queue, head at cylinder 1; no clearing pass. A word held by rsp_stall
// does not block the next request word; its result waits in res.
// ============================================================================
`default_nettype none

module sstf_disk_request_queue
  import sdrq_pkg::*;
#(
  parameter int QUEUE_DEPTH   = 64,
  parameter int CYLINDER_BITS = 13
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_stall,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_stall,
  output rsp_t      rsp
);

  localparam int CB = CYLINDER_BITS;
  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  state_t        state, state_next;
  cell_ctrl_t    ctrl;
  logic [CB-1:0] head;
  logic [CW-1:0] count;
  rsp_t          res;
  logic          res_valid;

  logic          accept, is_set, is_add, full, move, res_load;
  logic [CB-1:0] cyl_in;
  logic [CB+CYL_FIELD_W-1:0] cyl_in_w;
  logic          scan_done, scan_found;
  logic [CB-1:0] best_d, best_cyl;
  logic [IW-1:0] best_idx;
  logic [CW-1:0] count_inc, count_dec;
  logic [CW+COUNT_FIELD_W-1:0] cnt_w, cnt_inc_w, cnt_dec_w;
  logic [CB+CYL_FIELD_W-1:0]   cyl_out_w, seek_out_w;
  rsp_t          res_imm, res_srv;

  // input decode and size conversion
  assign accept   = req_valid && !req_stall;
  assign is_set   = req.command[CMD_SET_BIT];
  assign is_add   = req.command == CMD_ADD;
  assign full     = count == CW'(QUEUE_DEPTH);
  assign cyl_in_w = {{CB{1'b0}}, req.cylinder};
  assign cyl_in   = cyl_in_w[CB-1:0];

  // new words only in idle with the result slot free
  assign req_stall = (state != S_IDLE) || res_valid;

  // cell row
  sdrq_chain #(
    .DEPTH (QUEUE_DEPTH),
    .CB    (CB),
    .IW    (IW),
    .CW    (CW)
  ) u_chain (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .add_cyl  (cyl_in),
    .count    (count),
    .rm_idx   (best_idx),
    .head     (head),
    .done     (scan_done),
    .found    (scan_found),
    .best_d   (best_d),
    .best_idx (best_idx),
    .best_cyl (best_cyl)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (ctrl.start) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (scan_done) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // cell strobes
  always_comb begin
    ctrl = '0;
    unique case (state)
      S_IDLE: begin
        ctrl.add   = accept && !is_set && is_add && !full;
        ctrl.start = accept && !is_set && !is_add && (count != '0);
      end
      S_SCAN: begin
        ctrl.remove = scan_done;
      end
      default: ctrl = '0;
    endcase
  end

  // field conversions for the result word
  assign count_inc  = count + CW'(1);
  assign count_dec  = count - CW'(1);
  assign cnt_w      = {{COUNT_FIELD_W{1'b0}}, count};
  assign cnt_inc_w  = {{COUNT_FIELD_W{1'b0}}, count_inc};
  assign cnt_dec_w  = {{COUNT_FIELD_W{1'b0}}, count_dec};
  assign cyl_out_w  = {{CYL_FIELD_W{1'b0}}, best_cyl};
  assign seek_out_w = {{CYL_FIELD_W{1'b0}}, best_d};

  // results formed without a scan
  always_comb begin
    res_imm = '0;
    res_imm.queue_count = cnt_w[COUNT_FIELD_W-1:0];
    if (is_set) begin
      res_imm.status = STAT_HEAD;
    end else if (is_add) begin
      if (full) begin
        res_imm.status = STAT_FULL;
      end else begin
        res_imm.status      = STAT_ADDED;
        res_imm.queue_count = cnt_inc_w[COUNT_FIELD_W-1:0];
      end
    end else begin
      res_imm.status = STAT_EMPTY;
    end
  end

  // serve result at the end of the scan
  always_comb begin
    res_srv.status          = STAT_SERVED;
    res_srv.served_cylinder = cyl_out_w[CYL_FIELD_W-1:0];
    res_srv.seek_distance   = seek_out_w[CYL_FIELD_W-1:0];
    res_srv.queue_count     = cnt_dec_w[COUNT_FIELD_W-1:0];
  end

  assign res_load = (accept && !ctrl.start) || ctrl.remove;
  assign move     = res_valid && (!rsp_valid || !rsp_stall);

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= CB'(1);
      count     <= '0;
      res_valid <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept && is_set) begin
        head <= cyl_in;
      end else if (ctrl.remove) begin
        head <= best_cyl;
      end
      if (ctrl.add) begin
        count <= count_inc;
      end else if (ctrl.remove) begin
        count <= count_dec;
      end
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (move) begin
        res_valid <= 1'b0;
      end
      if (move) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (ctrl.remove) begin
      res <= res_srv;
    end else if (res_load) begin
      res <= res_imm;
    end
    if (move) begin
      rsp <= res;
    end
  end

`ifndef SYNTHESIS
  // token leaves the row only during a scan, and always with a pick
  a_done_in_scan: assert property (@(posedge clk) disable iff (rst)
    scan_done |-> (state == S_SCAN) && scan_found)
    else $error("search token finished outside a scan or without a pick");

  // a scan runs on a non-empty queue with the result slot free
  a_scan_clean: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> !res_valid && (count != '0))
    else $error("scan with pending result or empty queue");

  // head and count hold while the token is still walking
  a_scan_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) && !scan_done |=> (state == S_SCAN) && $stable(head) && $stable(count))
    else $error("queue state changed mid-scan");
`endif

endmodule

`default_nettype wire
